>>> rtl/srmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srmf_pkg;

  localparam int PIX_W          = 24;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;
  localparam int WIN_N          = 9;
  localparam int MEDIAN_RANK    = 4;
  localparam int WIDTH_W        = 11;
  localparam int HEIGHT_W       = 13;
  localparam int CFG_W          = 13;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int FIFO_DEPTH     = 8;

  localparam logic [PIX_W-1:0]    WHITE_PIXEL  = 24'hFF_FFFF;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/srmf_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none

module srmf_linebuf import srmf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic [PIX_W-1:0] pix_i,
  input  wire logic             up_wr_en_i,
  input  wire logic [AW-1:0]    up_wr_addr_i,
  output logic      [PIX_W-1:0] up_rd_o,
  output logic      [PIX_W-1:0] mid_rd_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  // The middle row is read and replaced by the new pixel at the same edge.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_rd_o               <= middle_mem[rd_addr_i];
      middle_mem[rd_addr_i]  <= pix_i;
    end
  end

  // In the cycle after the read, the old middle pixel moves up into the upper row.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_o <= upper_mem[rd_addr_i];
    end
    if (up_wr_en_i) begin
      upper_mem[up_wr_addr_i] <= mid_rd_o;
    end
  end

endmodule

`default_nettype wire

>>> rtl/srmf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module srmf_lane import srmf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic [CH_W-1:0] val_i [WIN_N],
  output logic      [CH_W-1:0] median_o
);

  logic [CH_W-1:0]  val_q [WIN_N];
  logic [WIN_N-1:0] lt_q  [WIN_N];
  logic [WIN_N-1:0] lt_d  [WIN_N];

  // lt[i][j] is set when value i is below value j.
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        lt_d[i][j] = val_i[i] < val_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_i;
    lt_q  <= lt_d;
  end

  // A value is the median when at most four others lie below it and at
  // least five values, itself included, lie at or below it.
  always_comb begin
    logic [3:0] n_lt;
    logic [3:0] n_le;
    median_o = val_q[0];
    for (int i = WIN_N - 1; i >= 0; i--) begin
      n_lt = '0;
      n_le = '0;
      for (int j = 0; j < WIN_N; j++) begin
        n_lt = n_lt + 4'(lt_q[j][i]);
        n_le = n_le + 4'(!lt_q[i][j]);
      end
      if (n_lt <= 4'(MEDIAN_RANK) && n_le >= 4'(MEDIAN_RANK + 1)) begin
        median_o = val_q[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/srmf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module srmf_fifo import srmf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_en_i,
  input  wire out_word_t wr_data_i,
  output logic           rd_valid_o,
  input  wire logic      rd_ready_i,
  output out_word_t      rd_data_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  out_word_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     cnt_q;
  logic              pop;

  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + NW'(wr_en_i) - NW'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/selective_rgb_median_filter.sv
// Selective 3x3 median filter on an RGB raster stream. One word is taken
// per clock when the output side keeps up; the window shift and both line
// store accesses finish in the cycle after a word is taken, so nothing in
// the datapath stalls the input. A result appears one row plus one pixel
// after its pixel, passing the s1, s2 and s3 registers to the output buffer,
// and up to eight results are buffered before the input stalls. Only an
// exactly white pixel is replaced, channel by channel, by the median of
// its window; edges and corners repeat pixels to fill nine values. After
// the last pixel, image_width+1 flush words drain the frame. Writing
// either register restarts the frame and must happen while idle.
`timescale 1ns / 1ps
`default_nettype none

module selective_rgb_median_filter import srmf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                op_i,
  input  wire logic [CH_W-1:0]     red_in_i,
  input  wire logic [CH_W-1:0]     green_in_i,
  input  wire logic [CH_W-1:0]     blue_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [CH_W-1:0]     red_out_o,
  output logic      [CH_W-1:0]     green_out_o,
  output logic      [CH_W-1:0]     blue_out_o,
  output logic                     frame_end_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [CW-1:0]       ew;
  logic [HEIGHT_W-1:0] eh_m1;

  logic [CW-1:0]       ic_q, ic_d, oc_q, oc_d, ic_eff, oc_eff, ic_inc;
  logic [1:0]          irow_q, irow_d, irow_eff;
  logic [HEIGHT_W-1:0] orow_q, orow_d, orow_eff;
  logic                restart;
  logic                accept, emit, top, bot, left, right, last;

  logic [NW-1:0]       pend_q, pend_d;
  logic                pop;

  logic [PIX_W-1:0]    pix;
  logic [PIX_W-1:0]    up_rd, mid_rd;

  logic                s1_valid_q, s1_emit_q, s1_ic0_q, s1_last_q;
  logic                s1_top_q, s1_bot_q, s1_left_q, s1_right_q;
  logic [AW-1:0]       s1_addr_q;
  logic [PIX_W-1:0]    s1_pix_q;

  logic [PIX_W-1:0]    win_q [WIN_N];
  logic [PIX_W-1:0]    win_d [WIN_N];
  logic [PIX_W-1:0]    nb    [3][3];
  logic [PIX_W-1:0]    vals  [WIN_N];

  logic                s2_valid_q, s2_last_q;
  logic [PIX_W-1:0]    s2_cen_q;
  logic [PIX_W-1:0]    s2_vals_q [WIN_N];
  logic                s3_valid_q, s3_last_q;
  logic [PIX_W-1:0]    s3_cen_q;

  logic [CH_W-1:0]     lane_in  [NUM_CH][WIN_N];
  logic [CH_W-1:0]     lane_med [NUM_CH];
  out_word_t           fifo_wr, fifo_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WIDTH_W'(2)) begin
      ew = CW'(2);
    end else if (int'(width_q) > MAX_WIDTH) begin
      ew = CW'(MAX_WIDTH);
    end else begin
      ew = CW'(width_q);
    end
    eh_m1 = (height_q < HEIGHT_W'(2)) ? HEIGHT_W'(1) : height_q - 1'b1;
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = pend_q < NW'(FIFO_DEPTH);
  assign pix        = (op_i == OP_FLUSH) ? '0 : {red_in_i, green_in_i, blue_in_i};

  always_comb begin
    restart  = ic_q >= ew;
    ic_eff   = restart ? '0 : ic_q;
    irow_eff = restart ? '0 : irow_q;
    oc_eff   = restart ? '0 : oc_q;
    orow_eff = restart ? '0 : orow_q;
    emit     = irow_eff[1] || (irow_eff == 2'd1 && ic_eff != '0);
    top      = orow_eff == '0;
    bot      = orow_eff == eh_m1;
    left     = oc_eff == '0;
    right    = oc_eff == ew - 1'b1;
    last     = bot && right;
    ic_inc   = ic_eff + 1'b1;

    ic_d   = ic_q;
    irow_d = irow_q;
    oc_d   = oc_q;
    orow_d = orow_q;
    if (accept) begin
      if (ic_inc >= ew) begin
        ic_d   = '0;
        irow_d = irow_eff[1] ? irow_eff : irow_eff + 1'b1;
      end else begin
        ic_d   = ic_inc;
        irow_d = irow_eff;
      end
      oc_d   = oc_eff;
      orow_d = orow_eff;
      if (emit) begin
        if (last) begin
          ic_d   = '0;
          irow_d = '0;
          oc_d   = '0;
          orow_d = '0;
        end else if (right) begin
          oc_d   = '0;
          orow_d = orow_eff + 1'b1;
        end else begin
          oc_d = oc_eff + 1'b1;
        end
      end
    end
    if (cfg_we_i) begin
      ic_d   = '0;
      irow_d = '0;
      oc_d   = '0;
      orow_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q   <= '0;
      irow_q <= '0;
      oc_q   <= '0;
      orow_q <= '0;
      pend_q <= '0;
    end else begin
      ic_q   <= ic_d;
      irow_q <= irow_d;
      oc_q   <= oc_d;
      orow_q <= orow_d;
      pend_q <= pend_d;
    end
  end

  assign pop    = out_valid_o && out_ready_i;
  assign pend_d = pend_q + NW'(accept && emit) - NW'(pop);

  srmf_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i        (clk_i),
    .rd_en_i      (accept),
    .rd_addr_i    (ic_eff[AW-1:0]),
    .pix_i        (pix),
    .up_wr_en_i   (s1_valid_q),
    .up_wr_addr_i (s1_addr_q),
    .up_rd_o      (up_rd),
    .mid_rd_o     (mid_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q  <= emit;
      s1_ic0_q   <= ic_eff == '0;
      s1_last_q  <= last;
      s1_top_q   <= top;
      s1_bot_q   <= bot;
      s1_left_q  <= left;
      s1_right_q <= right;
      s1_addr_q  <= ic_eff[AW-1:0];
      s1_pix_q   <= pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3 + 1] = win_q[r*3+2];
    end
    win_d[2] = up_rd;
    win_d[5] = mid_rd;
    win_d[8] = s1_pix_q;
    for (int r = 0; r < 3; r++) begin
      if (s1_ic0_q) begin
        nb[r][0] = win_q[r*3+1];
        nb[r][1] = win_q[r*3+2];
        nb[r][2] = '0;
      end else begin
        nb[r][0] = win_d[r*3];
        nb[r][1] = win_d[r*3+1];
        nb[r][2] = win_d[r*3+2];
      end
    end
  end

  always_comb begin
    logic [1:0] dr;
    logic [1:0] dc;
    dr = s1_top_q ? 2'd2 : 2'd0;
    dc = s1_left_q ? 2'd2 : 2'd0;
    if ((s1_top_q || s1_bot_q) && (s1_left_q || s1_right_q)) begin
      vals[0] = nb[1][1];   vals[1] = nb[1][1];
      vals[2] = nb[1][1];   vals[3] = nb[1][1];
      vals[4] = nb[1][dc];  vals[5] = nb[1][dc];
      vals[6] = nb[dr][1];  vals[7] = nb[dr][1];
      vals[8] = nb[dr][dc];
    end else if (s1_top_q || s1_bot_q) begin
      vals[0] = nb[1][1];   vals[1] = nb[1][1];
      vals[2] = nb[1][0];   vals[3] = nb[1][0];
      vals[4] = nb[1][2];   vals[5] = nb[1][2];
      vals[6] = nb[dr][0];  vals[7] = nb[dr][1];
      vals[8] = nb[dr][2];
    end else if (s1_left_q || s1_right_q) begin
      vals[0] = nb[1][1];   vals[1] = nb[1][1];
      vals[2] = nb[0][1];   vals[3] = nb[0][1];
      vals[4] = nb[2][1];   vals[5] = nb[2][1];
      vals[6] = nb[0][dc];  vals[7] = nb[1][dc];
      vals[8] = nb[2][dc];
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          vals[r*3 + c] = nb[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_N; k++) begin
        win_q[k] <= '0;
      end
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_valid_q) begin
        win_q <= win_d;
      end
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_vals_q <= vals;
    s2_cen_q  <= nb[1][1];
    s2_last_q <= s1_last_q;
    s3_cen_q  <= s2_cen_q;
    s3_last_q <= s2_last_q;
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    always_comb begin
      for (int k = 0; k < WIN_N; k++) begin
        lane_in[ch][k] = s2_vals_q[k][PIX_W-1-ch*CH_W -: CH_W];
      end
    end

    srmf_lane u_lane (
      .clk_i    (clk_i),
      .val_i    (lane_in[ch]),
      .median_o (lane_med[ch])
    );
  end

  always_comb begin
    fifo_wr.frame_end = s3_last_q;
    if (s3_cen_q == WHITE_PIXEL) begin
      fifo_wr.pixel = {lane_med[0], lane_med[1], lane_med[2]};
    end else begin
      fifo_wr.pixel = s3_cen_q;
    end
  end

  srmf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (s3_valid_q),
    .wr_data_i  (fifo_wr),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (fifo_rd)
  );

  assign red_out_o   = fifo_rd.pixel[PIX_W-1 -: CH_W];
  assign green_out_o = fifo_rd.pixel[PIX_W-1-CH_W -: CH_W];
  assign blue_out_o  = fifo_rd.pixel[CH_W-1:0];
  assign frame_end_o = fifo_rd.frame_end;

`ifndef NO_ASSERTIONS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= NW'(FIFO_DEPTH))
    else $error("pending word count exceeds the output buffer");

  a_out_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("output word present with no pending word");

  a_s1_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("taken word did not reach the window stage");
`endif

endmodule

`default_nettype wire

>>> sim/selective_rgb_median_filter_tb.sv
`timescale 1ns / 1ps

module selective_rgb_median_filter_tb;
  import srmf_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct packed {
    op_e              op;
    logic [PIX_W-1:0] pixel;
    logic             typed;
    out_word_t        word;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [0:0]          cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [CH_W-1:0]     red_in_i;
  logic [CH_W-1:0]     green_in_i;
  logic [CH_W-1:0]     blue_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CH_W-1:0]     red_out_o;
  logic [CH_W-1:0]     green_out_o;
  logic [CH_W-1:0]     blue_out_o;
  logic                frame_end_o;

  selective_rgb_median_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  // Filter state mirrored by the testbench.
  logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  logic [PIX_W-1:0]    upper_line [STORE_DEPTH];
  logic [PIX_W-1:0]    middle_line [STORE_DEPTH];
  logic [8:0][PIX_W-1:0] window_px = '0;
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  out_word_t   filtered_words[$];
  int unsigned err_count = 0;
  int unsigned words_in = 0, words_out = 0, frames_done = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req = 0;
  stim_row_t   directed_rows[20];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > STORE_DEPTH) return STORE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic logic [CH_W-1:0] channel_median(input logic [8:0][PIX_W-1:0] vals,
                                                     input int sh);
    logic [CH_W-1:0] ch[9];
    logic [CH_W-1:0] v;
    int j;
    for (int i = 0; i < 9; i++) ch[i] = CH_W'(vals[i] >> sh);
    for (int i = 1; i < 9; i++) begin
      v = ch[i];
      j = i - 1;
      while (j >= 0 && ch[j] > v) begin
        ch[j+1] = ch[j];
        j--;
      end
      ch[j+1] = v;
    end
    return ch[MEDIAN_RANK];
  endfunction

  // nb is indexed row*3+col around the center pixel.
  function automatic logic [PIX_W-1:0] median_pixel(input logic [8:0][PIX_W-1:0] nb,
                                                    input bit top, input bit bot,
                                                    input bit left, input bit right);
    logic [8:0][PIX_W-1:0] v;
    logic [PIX_W-1:0] c;
    int dr, dc;
    c = nb[4];
    dr = top ? 2 : 0;
    dc = left ? 2 : 0;
    if (c != WHITE_PIXEL) return c;
    if ((top || bot) && (left || right)) begin
      v[0] = c; v[1] = c; v[2] = c; v[3] = c;
      v[4] = nb[3+dc]; v[5] = nb[3+dc];
      v[6] = nb[dr*3+1]; v[7] = nb[dr*3+1];
      v[8] = nb[dr*3+dc];
    end else if (top || bot) begin
      v[0] = c; v[1] = c;
      v[2] = nb[3]; v[3] = nb[3];
      v[4] = nb[5]; v[5] = nb[5];
      v[6] = nb[dr*3]; v[7] = nb[dr*3+1]; v[8] = nb[dr*3+2];
    end else if (left || right) begin
      v[0] = c; v[1] = c;
      v[2] = nb[1]; v[3] = nb[1];
      v[4] = nb[7]; v[5] = nb[7];
      v[6] = nb[dc]; v[7] = nb[3+dc]; v[8] = nb[6+dc];
    end else begin
      v = nb;
    end
    return {channel_median(v, 16), channel_median(v, 8), channel_median(v, 0)};
  endfunction

  function automatic bit filter_word(input op_e op, input logic [PIX_W-1:0] px_in,
                                     output out_word_t word);
    int unsigned w, h, ic, idx;
    logic [PIX_W-1:0] px;
    logic [8:0][PIX_W-1:0] prev, nb;
    bit emit;
    w = eff_width();
    h = eff_height();
    if (in_col >= w) restart_frame();
    ic = in_col;
    idx = ic % STORE_DEPTH;
    px = (op == OP_PIXEL) ? px_in : '0;
    prev = window_px;
    for (int r = 0; r < 3; r++) begin
      window_px[r*3] = window_px[r*3+1];
      window_px[r*3+1] = window_px[r*3+2];
    end
    window_px[2] = upper_line[idx];
    window_px[5] = middle_line[idx];
    window_px[8] = px;
    upper_line[idx] = middle_line[idx];
    middle_line[idx] = px;
    emit = in_row >= 2 || (in_row == 1 && ic >= 1);
    in_col = ic + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    word = '0;
    if (!emit) return 0;
    for (int r = 0; r < 3; r++) begin
      if (ic >= 1) begin
        nb[r*3] = window_px[r*3];
        nb[r*3+1] = window_px[r*3+1];
        nb[r*3+2] = window_px[r*3+2];
      end else begin
        nb[r*3] = prev[r*3+1];
        nb[r*3+1] = prev[r*3+2];
        nb[r*3+2] = '0;
      end
    end
    word.pixel = median_pixel(nb, out_row == 0, out_row == h - 1,
                              out_col == 0, out_col == w - 1);
    word.frame_end = (out_row == h - 1) && (out_col == w - 1);
    if (word.frame_end) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned pick;
    logic [PIX_W-1:0] px;
    pick = $urandom_range(0, 9);
    px = PIX_W'($urandom);
    if (pick < 4) return WHITE_PIXEL;
    if (pick == 4) begin
      px = WHITE_PIXEL;
      px[$urandom_range(0, 2)*8 +: 8] = CH_W'($urandom);
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input op_e op, input logic [PIX_W-1:0] px, input bit typed,
                           input out_word_t typed_word);
    int unsigned gap;
    out_word_t word;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i <= op;
    red_in_i <= px[23:16];
    green_in_i <= px[15:8];
    blue_in_i <= px[7:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_in++;
    if (filter_word(op, px, word)) filtered_words.push_back(typed ? typed_word : word);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (filtered_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    if (idx == CFG_WIDTH) width_reg = WIDTH_W'(value);
    else height_reg = HEIGHT_W'(value);
    restart_frame();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_frame(input int unsigned w, input int unsigned h, input bit partial,
                           input bit hold, input bit pause);
    int unsigned ew, eh, total, stop_at;
    op_e op;
    settle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    ew = eff_width();
    eh = eff_height();
    total = ew * eh + ew + 1;
    stop_at = partial ? $urandom_range(1, (total > 41) ? 40 : total - 1) : total;
    for (int unsigned k = 0; k < stop_at; k++) begin
      if (hold && k == ew + 1) hold_req = 1;
      if (pause && k == total / 2) settle();
      if (k < ew * eh) op = ($urandom_range(0, 29) == 0) ? OP_FLUSH : OP_PIXEL;
      else op = ($urandom_range(0, 7) == 0) ? OP_PIXEL : OP_FLUSH;
      send_word(op, rand_pixel(), 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= OP_PIXEL;
    red_in_i <= '0;
    green_in_i <= '0;
    blue_in_i <= '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    directed_rows = '{
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_PIXEL, 24'h000000, 1'b0, '0},
      '{OP_PIXEL, 24'hFFFFFE, 1'b0, '0},
      '{OP_PIXEL, 24'h010203, 1'b0, '0},
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_PIXEL, 24'h804020, 1'b1, '{24'h000000, 1'b0}},
      '{OP_PIXEL, 24'hFF00FF, 1'b1, '{24'hFFFFFE, 1'b0}},
      '{OP_PIXEL, 24'hFFFFFF, 1'b1, '{24'h010203, 1'b0}},
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_FLUSH, 24'h123456, 1'b1, '{24'h804020, 1'b0}},
      '{OP_FLUSH, 24'h000000, 1'b1, '{24'hFF00FF, 1'b0}},
      '{OP_PIXEL, 24'hABCDEF, 1'b0, '0},
      '{OP_FLUSH, 24'h000000, 1'b0, '0},
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_PIXEL, 24'hFFFFFF, 1'b0, '0},
      '{OP_FLUSH, 24'hFFFFFF, 1'b0, '0},
      '{OP_FLUSH, 24'h000000, 1'b0, '0},
      '{OP_FLUSH, 24'h000000, 1'b0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default geometry straight out of reset, cut off mid-frame.
    for (int k = 0; k < 60; k++) send_word(OP_PIXEL, rand_pixel(), 1'b0, '0);

    for (int k = 0; k < 20; k++) begin
      if (k == 0 || k == 13) begin
        settle();
        write_reg(CFG_WIDTH, (k == 0) ? 3 : 2);
        write_reg(CFG_HEIGHT, (k == 0) ? 3 : 2);
      end
      send_word(directed_rows[k].op, directed_rows[k].pixel, directed_rows[k].typed,
                directed_rows[k].word);
    end

    for (int unsigned phase = 0, start = words_in; words_in - start < 300; phase++) begin
      run_frame($urandom_range(2, 12), $urandom_range(2, 8), $urandom_range(0, 4) == 0,
                phase == 2, phase == 4);
    end

    run_frame(2047, 2, 1'b1, 1'b0, 1'b0);
    run_frame(2, 8191, 1'b1, 1'b0, 1'b0);
    run_frame(0, 0, 1'b0, 1'b0, 1'b0);
    run_frame(1, 1, 1'b0, 1'b0, 1'b0);
    run_frame(6, 4, 1'b0, 1'b0, 1'b1);
    run_frame(7, 3, 1'b0, 1'b1, 1'b0);
    settle();

    $display("Sent %0d words, checked %0d filtered pixels over %0d complete frames.",
             words_in, words_out, frames_done);
    $display("Frames ranged from 2x2 up, with clamped widths and heights and tall frames cut short.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned rcv_cycle;
    int unsigned rcv_mode;
    rcv_cycle = 0;
    rcv_mode = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else begin
        if (rcv_cycle % 150 == 0) rcv_mode = $urandom_range(0, 3);
        rcv_cycle++;
        case (rcv_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rcv_cycle % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (filtered_words.size() == 0) begin
        report_mismatch("unexpected word", {red_out_o, green_out_o, blue_out_o}, 0);
      end else begin
        want = filtered_words.pop_front();
        if (red_out_o !== want.pixel[23:16])
          report_mismatch("red", red_out_o, want.pixel[23:16]);
        if (green_out_o !== want.pixel[15:8])
          report_mismatch("green", green_out_o, want.pixel[15:8]);
        if (blue_out_o !== want.pixel[7:0])
          report_mismatch("blue", blue_out_o, want.pixel[7:0]);
        if (frame_end_o !== want.frame_end)
          report_mismatch("frame_end", frame_end_o, want.frame_end);
        if (want.frame_end) frames_done++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
rtl/srmf_pkg.sv
rtl/srmf_linebuf.sv
rtl/srmf_lane.sv
rtl/srmf_fifo.sv
rtl/selective_rgb_median_filter.sv
sim/selective_rgb_median_filter_tb.sv
